FILE: rtl/lob_pkg.sv
// Shared types, codes and constants for the limit order book matcher.
package lob_pkg;

  localparam int BOOK_DEPTH_DEF = 32;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic RESULT_TRADE = 1'b0;
  localparam logic RESULT_DONE  = 1'b1;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DROP = 2'd2;
  localparam logic [1:0] OP_SETQ = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] order_id;
    logic        side;
    logic [23:0] quantity;
    logic [31:0] price_ticks;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [23:0] trade_quantity;
    logic [31:0] trade_price;
    logic [1:0]  status;
    logic        last;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic apply;
    logic match_step;
    logic emit_done;
  } lob_cmd_t;

  typedef struct packed {
    logic scan_stop;
    logic crossed;
  } lob_stat_t;

endpackage

FILE: rtl/lob_ctrl.sv
// Sequencer for one transaction: scan, apply, match loop, done marker.
module lob_ctrl
  import lob_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  lob_stat_t stat,
  output lob_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_MATCH = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_stop) begin
          state_nxt = ST_APPLY;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        if (stat.crossed) begin
          cmd.match_step = 1'b1;
        end else begin
          cmd.emit_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: rtl/lob_dp.sv
// Book storage, search pointer, match arithmetic and result register.
module lob_dp
  import lob_pkg::*;
#(
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_t       in_item,
  input  lob_cmd_t  cmd,
  output lob_stat_t stat,
  output logic      out_strobe,
  output out_t      out_item
);

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

  logic [31:0] px_r  [2][BOOK_DEPTH];
  logic [23:0] qty_r [2][BOOK_DEPTH];
  logic [31:0] id_r  [2][BOOK_DEPTH];
  logic [CW-1:0] count_r [2];

  in_t           req_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] ntr_r;
  logic [1:0]    status_r;
  logic          strobe_r;
  out_t          out_r;

  logic [1:0]    op      [2];
  logic [AW-1:0] op_pos  [2];
  logic [23:0]   op_qty  [2];

  logic [31:0] rd_px, rd_id;
  logic        at_end, hit, found, full;
  logic [23:0] bq0, sq0, tq;

  assign rd_px  = px_r[req_r.side][idx_r[AW-1:0]];
  assign rd_id  = id_r[req_r.side][idx_r[AW-1:0]];
  assign at_end = (idx_r == count_r[req_r.side]);
  assign found  = !at_end;
  assign full   = (count_r[req_r.side] >= DEPTH_C);

  always_comb begin
    case (req_r.kind)
      KIND_ADD:    hit = (req_r.side == SIDE_BUY) ? (rd_px < req_r.price_ticks)
                                                  : (rd_px > req_r.price_ticks);
      KIND_CANCEL: hit = (rd_id == req_r.order_id);
      KIND_MODIFY: hit = (rd_id == req_r.order_id);
      default:     hit = 1'b1;
    endcase
  end

  assign bq0 = qty_r[SIDE_BUY][0];
  assign sq0 = qty_r[SIDE_SELL][0];
  assign tq  = (bq0 < sq0) ? bq0 : sq0;

  assign stat.scan_stop = at_end || hit;
  assign stat.crossed = (count_r[SIDE_BUY] != '0) && (count_r[SIDE_SELL] != '0) &&
                        (ntr_r < DEPTH_C) && (px_r[SIDE_BUY][0] >= px_r[SIDE_SELL][0]);

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      op[s]     = OP_NONE;
      op_pos[s] = '0;
      op_qty[s] = '0;
    end
    if (cmd.apply) begin
      case (req_r.kind)
        KIND_ADD: begin
          if (!full && (req_r.quantity != '0)) begin
            op[req_r.side]     = OP_INS;
            op_pos[req_r.side] = idx_r[AW-1:0];
            op_qty[req_r.side] = req_r.quantity;
          end
        end
        KIND_CANCEL: begin
          if (found) begin
            op[req_r.side]     = OP_DROP;
            op_pos[req_r.side] = idx_r[AW-1:0];
          end
        end
        KIND_MODIFY: begin
          if (found) begin
            op[req_r.side]     = (req_r.quantity == '0) ? OP_DROP : OP_SETQ;
            op_pos[req_r.side] = idx_r[AW-1:0];
            op_qty[req_r.side] = req_r.quantity;
          end
        end
        default: ;
      endcase
    end
    if (cmd.match_step) begin
      // A side whose best order is used up loses it; a side with quantity left keeps the rest.
      op[SIDE_BUY]      = (bq0 == tq) ? OP_DROP : OP_SETQ;
      op_qty[SIDE_BUY]  = bq0 - tq;
      op[SIDE_SELL]     = (sq0 == tq) ? OP_DROP : OP_SETQ;
      op_qty[SIDE_SELL] = sq0 - tq;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < BOOK_DEPTH; i++) begin
        case (op[s])
          OP_INS: begin
            if (AW'(i) == op_pos[s]) begin
              px_r[s][i]  <= req_r.price_ticks;
              qty_r[s][i] <= op_qty[s];
              id_r[s][i]  <= req_r.order_id;
            end else if (AW'(i) > op_pos[s]) begin
              px_r[s][i]  <= px_r[s][(i == 0) ? 0 : i - 1];
              qty_r[s][i] <= qty_r[s][(i == 0) ? 0 : i - 1];
              id_r[s][i]  <= id_r[s][(i == 0) ? 0 : i - 1];
            end
          end
          OP_DROP: begin
            if (AW'(i) >= op_pos[s]) begin
              px_r[s][i]  <= px_r[s][(i + 1 < BOOK_DEPTH) ? i + 1 : i];
              qty_r[s][i] <= qty_r[s][(i + 1 < BOOK_DEPTH) ? i + 1 : i];
              id_r[s][i]  <= id_r[s][(i + 1 < BOOK_DEPTH) ? i + 1 : i];
            end
          end
          OP_SETQ: begin
            if (AW'(i) == op_pos[s]) begin
              qty_r[s][i] <= op_qty[s];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r[0] <= '0;
      count_r[1] <= '0;
      idx_r      <= '0;
      ntr_r      <= '0;
      strobe_r   <= 1'b0;
    end else begin
      for (int s = 0; s < 2; s++) begin
        if (op[s] == OP_INS) begin
          count_r[s] <= count_r[s] + 1'b1;
        end else if (op[s] == OP_DROP) begin
          count_r[s] <= count_r[s] - 1'b1;
        end
      end
      if (cmd.load) begin
        idx_r <= '0;
        ntr_r <= '0;
      end else if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.match_step) begin
        ntr_r <= ntr_r + 1'b1;
      end
      strobe_r <= cmd.match_step || cmd.emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (cmd.apply) begin
      if ((req_r.kind == KIND_ADD) && full) begin
        status_r <= STATUS_FULL;
      end else if (((req_r.kind == KIND_CANCEL) || (req_r.kind == KIND_MODIFY)) && !found) begin
        status_r <= STATUS_NOT_FOUND;
      end else begin
        status_r <= STATUS_OK;
      end
    end
    if (cmd.match_step) begin
      out_r.result_kind    <= RESULT_TRADE;
      out_r.trade_quantity <= tq;
      out_r.trade_price    <= px_r[SIDE_SELL][0];
      out_r.status         <= STATUS_OK;
      out_r.last           <= 1'b0;
    end else if (cmd.emit_done) begin
      out_r.result_kind    <= RESULT_DONE;
      out_r.trade_quantity <= '0;
      out_r.trade_price    <= '0;
      out_r.status         <= status_r;
      out_r.last           <= 1'b1;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

FILE: rtl/limit_order_book_matcher_core.sv
// Top level of the price-time priority limit order book matcher.
//
//   channel | ports                     | transfer
//   input   | start, busy, in_item      | start high while busy low
//   result  | out_strobe, out_item      | out_strobe marks each result, no back-pressure
//
// A transaction is loaded, then the search passes over the entries of its side
// one entry a cycle (up to the side's fill count) until an entry stops it or the
// end is reached; then the change is applied, trades are formed one per cycle,
// and a done marker ends it. Results are registered and appear in the cycle after
// they are formed. Reset empties both books at once; the receiver cannot stall.
module limit_order_book_matcher_core
  import lob_pkg::*;
#(
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_strobe,
  output out_t out_item
);

  lob_cmd_t  cmd;
  lob_stat_t stat;

  lob_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lob_dp #(
    .BOOK_DEPTH (BOOK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

FILE: verif/lob_checker.sv
// Scoreboard for the order book matcher: watches both channels, predicts results and compares.
`timescale 1ns / 100ps
module lob_checker
  import lob_pkg::*;
#(
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_item,
  input  logic out_strobe,
  input  out_t out_item,
  output int   pending,
  output int   errors
);

  localparam int FIFO_DEPTH = 128;

  logic [31:0] book_px  [2][BOOK_DEPTH];
  logic [23:0] book_qty [2][BOOK_DEPTH];
  logic [31:0] book_id  [2][BOOK_DEPTH];
  logic [31:0] book_arr [2][BOOK_DEPTH];
  int          book_cnt [2];
  logic [31:0] next_arrival;
  out_t        exp_fifo [FIFO_DEPTH];
  int          exp_wr;
  int          exp_rd;

  function automatic void queue_result(out_t r);
    exp_fifo[exp_wr % FIFO_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic void remove_entry(int s, int pos);
    for (int i = pos; i + 1 < book_cnt[s]; i++) begin
      book_px[s][i]  = book_px[s][i+1];
      book_qty[s][i] = book_qty[s][i+1];
      book_id[s][i]  = book_id[s][i+1];
      book_arr[s][i] = book_arr[s][i+1];
    end
    book_cnt[s]--;
  endfunction

  function automatic int locate(int s, logic [31:0] id);
    for (int i = 0; i < book_cnt[s]; i++)
      if (book_id[s][i] == id) return i;
    return -1;
  endfunction

  function automatic void place_order(int s, in_t it, logic [31:0] arr);
    int pos;
    pos = 0;
    // A new order goes behind every resting order at the same price.
    while (pos < book_cnt[s]) begin
      if (s == SIDE_BUY ? (book_px[s][pos] < it.price_ticks)
                        : (book_px[s][pos] > it.price_ticks)) break;
      pos++;
    end
    for (int i = book_cnt[s]; i > pos; i--) begin
      book_px[s][i]  = book_px[s][i-1];
      book_qty[s][i] = book_qty[s][i-1];
      book_id[s][i]  = book_id[s][i-1];
      book_arr[s][i] = book_arr[s][i-1];
    end
    book_px[s][pos]  = it.price_ticks;
    book_qty[s][pos] = it.quantity;
    book_id[s][pos]  = it.order_id;
    book_arr[s][pos] = arr;
    book_cnt[s]++;
  endfunction

  function automatic void apply_and_match(in_t it);
    logic [1:0]  st;
    int          s;
    int          pos;
    int          trades;
    logic [23:0] fill;
    out_t        r;
    st = STATUS_OK;
    s = int'(it.side);
    trades = 0;
    if (it.kind == KIND_ADD) begin
      if (book_cnt[s] >= BOOK_DEPTH) st = STATUS_FULL;
      else if (it.quantity != 0) place_order(s, it, next_arrival);
      next_arrival = next_arrival + 1;
    end else if (it.kind == KIND_CANCEL) begin
      pos = locate(s, it.order_id);
      if (pos < 0) st = STATUS_NOT_FOUND;
      else remove_entry(s, pos);
    end else if (it.kind == KIND_MODIFY) begin
      pos = locate(s, it.order_id);
      if (pos < 0) st = STATUS_NOT_FOUND;
      else if (it.quantity == 0) remove_entry(s, pos);
      else book_qty[s][pos] = it.quantity;
    end
    while (book_cnt[SIDE_BUY] > 0 && book_cnt[SIDE_SELL] > 0 && trades < BOOK_DEPTH &&
           book_px[SIDE_BUY][0] >= book_px[SIDE_SELL][0]) begin
      fill = (book_qty[SIDE_BUY][0] < book_qty[SIDE_SELL][0]) ? book_qty[SIDE_BUY][0]
                                                               : book_qty[SIDE_SELL][0];
      r = '0;
      r.result_kind = RESULT_TRADE;
      r.trade_quantity = fill;
      r.trade_price = book_px[SIDE_SELL][0];
      queue_result(r);
      trades++;
      book_qty[SIDE_BUY][0] -= fill;
      book_qty[SIDE_SELL][0] -= fill;
      if (book_qty[SIDE_BUY][0] == 0) remove_entry(SIDE_BUY, 0);
      if (book_qty[SIDE_SELL][0] == 0) remove_entry(SIDE_SELL, 0);
    end
    r = '0;
    r.result_kind = RESULT_DONE;
    r.status = st;
    r.last = 1'b1;
    queue_result(r);
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      book_cnt[0] = 0;
      book_cnt[1] = 0;
      next_arrival = '0;
      exp_wr = 0;
      exp_rd = 0;
      errors = 0;
    end else begin
      if (out_strobe) begin
        if (exp_wr == exp_rd) begin
          $error("result transaction with nothing expected: %p", out_item);
          errors++;
        end else begin
          exp_r = exp_fifo[exp_rd % FIFO_DEPTH];
          exp_rd++;
          if (out_item.result_kind !== exp_r.result_kind) begin
            $error("result_kind expected %0d actual %0d", exp_r.result_kind,
                   out_item.result_kind);
            errors++;
          end
          if (out_item.trade_quantity !== exp_r.trade_quantity) begin
            $error("trade_quantity expected %0d actual %0d", exp_r.trade_quantity,
                   out_item.trade_quantity);
            errors++;
          end
          if (out_item.trade_price !== exp_r.trade_price) begin
            $error("trade_price expected %0d actual %0d", exp_r.trade_price,
                   out_item.trade_price);
            errors++;
          end
          if (out_item.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, out_item.status);
            errors++;
          end
          if (out_item.last !== exp_r.last) begin
            $error("last expected %0d actual %0d", exp_r.last, out_item.last);
            errors++;
          end
        end
      end
      if (start && !busy) apply_and_match(in_item);
    end
    pending = exp_wr - exp_rd;
  end

endmodule

FILE: verif/tb_limit_order_book_matcher_core.sv
// Testbench top for the order book matcher: reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_limit_order_book_matcher_core;
  import lob_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int POOL = 24;
  localparam int RANDOM_ITEMS = 134;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_strobe;
  out_t out_item;
  int   pending;
  int   errors;
  logic [31:0] id_pool[POOL];

  always #2 clk = ~clk;

  limit_order_book_matcher_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  lob_checker scoreboard (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .pending(pending), .errors(errors)
  );

  // One transaction: random idle gap, then hold start until the block takes it.
  task automatic send_order(logic [1:0] kind, logic [31:0] id, logic side,
                            logic [23:0] qty, logic [31:0] px);
    int gap;
    in_t it;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    it.kind = kind;
    it.order_id = id;
    it.side = side;
    it.quantity = qty;
    it.price_ticks = px;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= it;
    start <= 1'b1;
    // The transaction is taken at the first edge at which busy is low.
    @(posedge clk iff !busy);
  endtask

  function automatic logic [23:0] rand_qty();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'd0;
    if (r == 1) return 24'($urandom());
    if (r == 2) return 24'hFFFFFF;
    return 24'($urandom_range(1, 100));
  endfunction

  function automatic logic [31:0] rand_price(logic side);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return side == SIDE_BUY ? $urandom_range(990, 1010) : $urandom_range(995, 1015);
  endfunction

  initial begin
    int sel;
    int sent;
    logic sd;
    for (int i = 0; i < POOL; i++) id_pool[i] = $urandom();
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFFFFFF;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, every kind, crossing, and the special cases.
    send_order(KIND_ADD, id_pool[0], SIDE_BUY, 24'hFFFFFF, 32'h0);
    send_order(KIND_ADD, id_pool[1], SIDE_SELL, 24'd10, 32'hFFFFFFFF);
    send_order(KIND_ADD, id_pool[2], SIDE_BUY, 24'd0, 32'd500);
    send_order(KIND_ADD, id_pool[3], SIDE_BUY, 24'd5, 32'hFFFFFFFF);
    send_order(KIND_MODIFY, id_pool[0], SIDE_BUY, 24'd7, 32'h0);
    send_order(KIND_CANCEL, id_pool[9], SIDE_SELL, 24'd0, 32'h0);
    send_order(KIND_MODIFY, id_pool[9], SIDE_BUY, 24'd3, 32'h0);
    send_order(KIND_UNUSED, id_pool[0], SIDE_BUY, 24'hFFFFFF, 32'hFFFFFFFF);
    send_order(KIND_ADD, id_pool[4], SIDE_SELL, 24'd20, 32'd1000);
    send_order(KIND_ADD, id_pool[5], SIDE_SELL, 24'd20, 32'd1000);
    send_order(KIND_ADD, id_pool[4], SIDE_SELL, 24'd20, 32'd1000);
    send_order(KIND_ADD, id_pool[6], SIDE_BUY, 24'd50, 32'd1000);
    send_order(KIND_CANCEL, id_pool[4], SIDE_SELL, 24'd0, 32'h0);
    send_order(KIND_MODIFY, id_pool[0], SIDE_BUY, 24'd0, 32'h0);
    send_order(KIND_CANCEL, id_pool[1], SIDE_SELL, 24'd0, 32'h0);
    send_order(KIND_ADD, id_pool[7], SIDE_SELL, 24'hFFFFFF, 32'd0);

    // Random part: mostly orders around one price level, with bursts that fill a side.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      sd = 1'($urandom_range(0, 1));
      if (sel < 3 && sent + 34 <= RANDOM_ITEMS) begin
        for (int k = 0; k < 34; k++)
          send_order(KIND_ADD, id_pool[$urandom_range(0, POOL-1)], sd,
                     24'($urandom_range(1, 50)), sd == SIDE_BUY ? 32'd10 : 32'd90000);
        sent = sent + 33;
      end else if (sel < 55) begin
        send_order(KIND_ADD, id_pool[$urandom_range(0, POOL-1)], sd, rand_qty(),
                   rand_price(sd));
      end else if (sel < 75) begin
        send_order(KIND_CANCEL, id_pool[$urandom_range(0, POOL-1)], sd, rand_qty(),
                   $urandom());
      end else if (sel < 95) begin
        send_order(KIND_MODIFY, id_pool[$urandom_range(0, POOL-1)], sd, rand_qty(),
                   $urandom());
      end else begin
        send_order(sel[0] ? KIND_UNUSED : KIND_ADD, $urandom(), sd, rand_qty(), $urandom());
      end
      sent++;
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
